// File: design/b64e_pkg.sv
// Shared types and constants for the base64 stream encoder.
// No dependencies; used by every module of the block.
package b64e_pkg;

  // Padding character '='.
  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // Depth of the job queue between the front and back parts.
  localparam int JobDepth = 2;
  localparam int LevelW   = $clog2(JobDepth + 1);
  localparam int PtrW     = $clog2(JobDepth);

  // One encoded job: up to four characters from one input word.
  typedef struct packed {
    logic [3:0][6:0] chars;     // characters, index 0 goes out first
    logic [1:0]      last_idx;  // index of the last valid character
    logic            fin;       // job ends the message
  } job_t;

  // Queue head as seen by the back part.
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  // Map a 6-bit group to its character of the standard alphabet.
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

// File: design/base64_stream_encoder.sv
// Top level of the streaming base64 encoder; instantiates b64e_front,
// b64e_queue and b64e_back and depends on b64e_pkg.
//
// Encodes a byte stream into standard base64 characters (A-Z a-z 0-9 + /)
// with '=' padding. Each input word carries one byte; tlast marks the final
// byte of a message, which flushes the partial group, pads the output to a
// multiple of four characters and raises out_tlast on the last character.
// A byte is accepted whenever the two-entry job queue has room; the output
// delivers one character per cycle while out_tready is high and a job is
// queued, so the sustained rate is set by the output port: a byte yields one
// to four characters; a message averages four per three bytes before padding.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] code_char, [7] zero fill
  output logic       out_tlast   // final_char
);

  logic                         push;
  b64e_pkg::job_t               push_job;
  logic                         space_ok;
  logic                         pop;
  b64e_pkg::head_t              head;
  logic [b64e_pkg::LevelW-1:0]  level;
  logic [6:0]                   out_char;

  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_fin   (in_tlast),
    .space_ok (space_ok),
    .in_ready (in_tready),
    .push     (push),
    .push_job (push_job)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .space_ok (space_ok),
    .head     (head),
    .level    (level)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .out_ready (out_tready),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

  // The queue never holds more jobs than its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= b64e_pkg::LevelW'(b64e_pkg::JobDepth))
    else $error("job queue level exceeds its depth");

  // A word is accepted only while the queue has room.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (level != b64e_pkg::LevelW'(b64e_pkg::JobDepth)))
    else $error("input accepted with a full job queue");

  // Padding that does not end the message is followed at once by more padding.
  a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast && out_tdata[6:0] == b64e_pkg::PAD_CHAR)
    |=> (out_tvalid && out_tdata[6:0] == b64e_pkg::PAD_CHAR))
    else $error("padding run broken");

  // The back part pops only while the queue holds a job.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from an empty job queue");

endmodule

// File: design/b64e_front.sv
// Front part of the base64 encoder: accepts input words, tracks the byte
// phase and leftover bits, and builds one job of characters per word.
// Depends on b64e_pkg.
module b64e_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_fin,
  input  logic            space_ok,
  output logic            in_ready,
  output logic            push,
  output b64e_pkg::job_t  push_job
);

  typedef enum logic [1:0] {
    PH_G0 = 2'd0,
    PH_G1 = 2'd1,
    PH_G2 = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;

  assign in_ready = space_ok;
  assign push     = in_valid && space_ok;

  // Build the job and the next state from the current phase.
  always_comb begin
    push_job          = '0;
    push_job.fin      = in_fin;
    push_job.chars[2] = b64e_pkg::PAD_CHAR;
    push_job.chars[3] = b64e_pkg::PAD_CHAR;
    phase_nxt         = phase_r;
    left_nxt          = left_r;
    case (phase_r)
      PH_G1: begin
        push_job.chars[0] = b64e_pkg::b64_char({left_r[1:0], in_byte[7:4]});
        push_job.chars[1] = b64e_pkg::b64_char({in_byte[3:0], 2'b00});
        push_job.last_idx = in_fin ? 2'd2 : 2'd0;
        left_nxt          = in_byte[3:0];
        phase_nxt         = PH_G2;
      end
      PH_G2: begin
        push_job.chars[0] = b64e_pkg::b64_char({left_r, in_byte[7:6]});
        push_job.chars[1] = b64e_pkg::b64_char(in_byte[5:0]);
        push_job.last_idx = 2'd1;
        left_nxt          = 4'd0;
        phase_nxt         = PH_G0;
      end
      default: begin
        push_job.chars[0] = b64e_pkg::b64_char(in_byte[7:2]);
        push_job.chars[1] = b64e_pkg::b64_char({in_byte[1:0], 4'b0000});
        push_job.last_idx = in_fin ? 2'd3 : 2'd0;
        left_nxt          = {2'b00, in_byte[1:0]};
        phase_nxt         = PH_G1;
      end
    endcase
    // The final word restarts the group for the next message.
    if (in_fin) begin
      left_nxt  = 4'd0;
      phase_nxt = PH_G0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_G0;
      left_r  <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// File: design/b64e_queue.sv
// Short job queue between the front and back parts of the base64 encoder.
// Depends on b64e_pkg.
module b64e_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  b64e_pkg::job_t               push_job,
  input  logic                         pop,
  output logic                         space_ok,
  output b64e_pkg::head_t              head,
  output logic [b64e_pkg::LevelW-1:0]  level
);

  b64e_pkg::job_t                mem_r [b64e_pkg::JobDepth];
  logic [b64e_pkg::PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [b64e_pkg::LevelW-1:0]   level_r;

  assign space_ok   = (level_r != b64e_pkg::LevelW'(b64e_pkg::JobDepth));
  assign head.valid = (level_r != '0);
  assign head.job   = mem_r[rd_ptr_r];
  assign level      = level_r;

  // Storage for queued jobs.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == b64e_pkg::PtrW'(b64e_pkg::JobDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == b64e_pkg::PtrW'(b64e_pkg::JobDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

endmodule

// File: design/b64e_back.sv
// Back part of the base64 encoder: sends the characters of the queue head
// one word per cycle, while out_ready is high, through a registered output stage.
// Depends on b64e_pkg.
module b64e_back (
  input  logic             clk,
  input  logic             rst_n,
  input  b64e_pkg::head_t  head,
  input  logic             out_ready,
  output logic             pop,
  output logic             out_valid,
  output logic [6:0]       out_char,
  output logic             out_last
);

  logic       valid_r;
  logic [6:0] char_r;
  logic       last_r;
  logic [1:0] idx_r;
  logic       load;
  logic       job_done;

  // The output register takes a new word when empty or being drained.
  assign load     = head.valid && (!valid_r || out_ready);
  assign job_done = (idx_r == head.job.last_idx);
  assign pop      = load && job_done;

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

  // Output stage and character index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= job_done ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Payload of the output stage.
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= head.job.chars[idx_r];
      last_r <= job_done && head.job.fin;
    end
  end

endmodule
